### hw/rtl/discharge_capacity_meter_assert.svh
// Assertion macros shared by the discharge capacity meter RTL.
`ifndef DISCHARGE_CAPACITY_METER_ASSERT_SVH
`define DISCHARGE_CAPACITY_METER_ASSERT_SVH

// Whenever ante holds, cons holds in the same cycle.
`define DCM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("discharge capacity meter: same-cycle check failed");

// Whenever ante holds, cons holds in the next cycle.
`define DCM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("discharge capacity meter: next-cycle check failed");

`endif

### hw/rtl/dcm_pkg.sv
// Types, constants and fixed-point helpers for the discharge capacity meter.
package dcm_pkg;

  localparam int SAMPLE_W   = 10;
  localparam int AVG_W      = 10;
  localparam int SUM_W      = 16;
  localparam int TICK_W     = 6;
  localparam int REM_W      = 13;
  localparam int MAH_W      = 16;
  localparam int DRIVE_W    = 7;
  localparam int CUR_SET_W  = 5;
  localparam int CUT_SET_W  = 6;
  localparam int THR_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 48;

  // item kinds, carried in tuser
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_KEY  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF  = 2'd1;

  localparam logic [TICK_W-1:0]    WINDOW      = 6'd50;
  localparam logic [REM_W-1:0]     MAS_PER_MAH = 13'd3600;
  localparam logic [CUR_SET_W-1:0] CUR_RESET   = 5'd10;
  localparam logic [CUR_SET_W-1:0] CUR_MAX     = 5'd20;
  localparam logic [CUR_SET_W-1:0] CUR_MIN     = 5'd1;
  localparam logic [CUT_SET_W-1:0] CUT_RESET   = 6'd30;
  localparam logic [CUT_SET_W-1:0] CUT_MAX     = 6'd50;
  localparam logic [CUT_SET_W-1:0] CUT_MIN     = 6'd1;
  localparam logic [2:0]           DRIVE_STEP  = 3'd6;

  // biased window average = floor((sum + 14) / 50) = floor(((sum + 14) >> 1) / 25)
  localparam logic [SUM_W:0] ROUND_BIAS = 17'd14;
  localparam logic [16:0]    AVG_RECIP  = 17'd83887;      // ceil(2^21 / 25)
  localparam int             AVG_SHIFT  = 21;
  // floor(a * 58 / 100) = floor(29a / 50), 29 * ceil(2^21 / 50)
  localparam logic [20:0]    CHG_RECIP  = 21'd1216376;
  localparam int             CHG_SHIFT  = 21;
  // floor(s * 2053 / 100), 2053 * ceil(2^24 / 100)
  localparam logic [28:0]    CUT_RECIP  = 29'd344437969;
  localparam int             CUT_SHIFT  = 24;

  typedef struct packed {
    logic             kind;
    logic [SUM_W-1:0] csum;
    logic [SUM_W-1:0] vsum;
  } sum_item_t;

  typedef struct packed {
    logic             kind;
    logic [AVG_W-1:0] avg_cur;
    logic [AVG_W-1:0] avg_vol;
  } avg_item_t;

  typedef struct packed {
    logic             kind;
    logic [AVG_W-1:0] avg_cur;
    logic [AVG_W-1:0] avg_vol;
    logic [AVG_W-1:0] charge;
  } chg_item_t;

  // first member lands in the highest bits
  typedef struct packed {
    logic               cutoff_hit;
    logic [DRIVE_W-1:0] drive_level;
    logic               discharging;
    logic [MAH_W-1:0]   capacity_mah;
    logic [AVG_W-1:0]   avg_voltage;
    logic [AVG_W-1:0]   avg_current;
  } result_t;

  function automatic logic [AVG_W-1:0] window_avg(input logic [SUM_W-1:0] sum);
    logic [SUM_W:0]   biased;
    logic [SUM_W-1:0] half;
    logic [32:0]      prod;
    biased = {1'b0, sum} + ROUND_BIAS;
    half   = biased[SUM_W:1];
    prod   = {17'b0, half} * {16'b0, AVG_RECIP};
    return prod[AVG_SHIFT +: AVG_W];
  endfunction

  function automatic logic [AVG_W-1:0] charge_of(input logic [AVG_W-1:0] avg);
    logic [30:0] prod;
    prod = {21'b0, avg} * {10'b0, CHG_RECIP};
    return prod[CHG_SHIFT +: AVG_W];
  endfunction

  function automatic logic [THR_W-1:0] cutoff_thr(input logic [CUT_SET_W-1:0] set);
    logic [34:0] prod;
    prod = {29'b0, set} * {6'b0, CUT_RECIP};
    return prod[CUT_SHIFT +: THR_W];
  endfunction

endpackage

### hw/rtl/discharge_capacity_meter.sv
// Discharge capacity meter: window averaging, charge counting and low-voltage cutoff.
//
//  channel | direction | tdata / data                      | tuser / index
//  in_     | slave     | current_sample, voltage_sample     | action
//  out_    | master    | avgs, capacity, state, drive, hit  | -
//  cfg_    | slave     | setting value                      | register index
//
//  One item per cycle is accepted while in_tready is high; a result leaves only for a key
//  item or a tick that ends a window. It passes the accumulator, average multiplier, charge
//  multiplier and state update into the output register, in that order.
//  Reset (rst_n low, synchronous) clears sums, counters, charge and stops discharge.
//  A stalled output lets the three inner stages fill before in_tready drops.
`include "discharge_capacity_meter_assert.svh"

module discharge_capacity_meter
  import dcm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [9:0] current_sample, [19:10] voltage_sample
  input  logic                  in_tuser,   // [0] action
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [9:0] avg_current, [19:10] avg_voltage,
                                            // [35:20] capacity_mah, [36] discharging,
                                            // [43:37] drive_level, [44] cutoff_hit
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [CUR_SET_W-1:0] cur_set_r;
  logic [CUT_SET_W-1:0] cut_set_r;
  logic [THR_W-1:0]     thr_r;

  logic [TICK_W-1:0] tick_r, tick_nxt, tick_inc;
  logic [SUM_W-1:0]  csum_r, csum_nxt, csum_add;
  logic [SUM_W-1:0]  vsum_r, vsum_nxt, vsum_add;
  logic              win_end;

  logic      v2_r, v3_r, v4_r;
  sum_item_t s2_r, s2_nxt;
  avg_item_t s3_r;
  chg_item_t s4_r;
  logic      rdy2, rdy3, rdy4, adv_out;
  logic      acc_in, load2, fire4;

  logic             running_r, running_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt, rem_sum;
  logic [MAH_W-1:0] mah_r, mah_nxt;
  logic [AVG_W-1:0] last_cur_r, last_cur_nxt;
  logic [AVG_W-1:0] last_vol_r, last_vol_nxt;
  logic             hit;

  logic    out_valid_r;
  result_t out_r, res;

  // ---------------- configuration ----------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_set_r <= CUR_RESET;
      cut_set_r <= CUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CURRENT: begin
          if (cfg_data[CUR_SET_W-1:0] == '0) cur_set_r <= CUR_MAX;
          else if (cfg_data[CUR_SET_W-1:0] > CUR_MAX) cur_set_r <= CUR_MIN;
          else cur_set_r <= cfg_data[CUR_SET_W-1:0];
        end
        REG_CUTOFF: begin
          if (cfg_data == '0) cut_set_r <= CUT_MAX;
          else if (cfg_data > CUT_MAX) cut_set_r <= CUT_MIN;
          else cut_set_r <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  // threshold is registered from the cutoff setting
  always_ff @(posedge clk) begin
    thr_r <= cutoff_thr(cut_set_r);
  end

  // ---------------- flow control ----------------
  assign adv_out   = !out_valid_r || out_tready;
  assign rdy4      = !v4_r || adv_out;
  assign rdy3      = !v3_r || rdy4;
  assign rdy2      = !v2_r || rdy3;
  assign in_tready = rdy2;
  assign acc_in    = in_tvalid && in_tready;
  assign fire4     = v4_r && adv_out;

  // ---------------- stage 1: accumulate ----------------
  assign tick_inc = tick_r + 1'b1;
  assign win_end  = (tick_inc == WINDOW);
  assign csum_add = csum_r + {{(SUM_W-SAMPLE_W){1'b0}}, in_tdata[SAMPLE_W-1:0]};
  assign vsum_add = vsum_r + {{(SUM_W-SAMPLE_W){1'b0}}, in_tdata[2*SAMPLE_W-1:SAMPLE_W]};

  always_comb begin
    tick_nxt = tick_r;
    csum_nxt = csum_r;
    vsum_nxt = vsum_r;
    load2    = 1'b0;
    s2_nxt   = '{kind: in_tuser, csum: csum_add, vsum: vsum_add};
    if (acc_in) begin
      if (in_tuser == ACT_KEY) begin
        load2 = 1'b1;
      end else if (win_end) begin
        load2    = 1'b1;
        tick_nxt = '0;
        csum_nxt = '0;
        vsum_nxt = '0;
      end else begin
        tick_nxt = tick_inc;
        csum_nxt = csum_add;
        vsum_nxt = vsum_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= '0;
      csum_r <= '0;
      vsum_r <= '0;
    end else begin
      tick_r <= tick_nxt;
      csum_r <= csum_nxt;
      vsum_r <= vsum_nxt;
    end
  end

  // ---------------- stages 2 and 3: averages, charge ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy2) v2_r <= load2;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) s2_r <= s2_nxt;
    if (rdy3) begin
      s3_r.kind    <= s2_r.kind;
      s3_r.avg_cur <= window_avg(s2_r.csum);
      s3_r.avg_vol <= window_avg(s2_r.vsum);
    end
    if (rdy4) begin
      s4_r.kind    <= s3_r.kind;
      s4_r.avg_cur <= s3_r.avg_cur;
      s4_r.avg_vol <= s3_r.avg_vol;
      s4_r.charge  <= charge_of(s3_r.avg_cur);
    end
  end

  // ---------------- stage 4: state update and result ----------------
  assign rem_sum = rem_r + {{(REM_W-AVG_W){1'b0}}, s4_r.charge};

  always_comb begin
    running_nxt  = running_r;
    rem_nxt      = rem_r;
    mah_nxt      = mah_r;
    last_cur_nxt = last_cur_r;
    last_vol_nxt = last_vol_r;
    hit          = 1'b0;
    if (fire4) begin
      if (s4_r.kind == ACT_KEY) begin
        running_nxt = !running_r;
      end else begin
        last_cur_nxt = s4_r.avg_cur;
        last_vol_nxt = s4_r.avg_vol;
        if (running_r) begin
          if (rem_sum > MAS_PER_MAH) begin
            rem_nxt = rem_sum - MAS_PER_MAH;
            mah_nxt = mah_r + 1'b1;
          end else begin
            rem_nxt = rem_sum;
          end
        end
        if ({1'b0, s4_r.avg_vol} < thr_r) begin
          hit         = running_r;
          running_nxt = 1'b0;
        end
      end
    end
  end

  always_comb begin
    res.avg_current  = last_cur_nxt;
    res.avg_voltage  = last_vol_nxt;
    res.capacity_mah = mah_nxt;
    res.discharging  = running_nxt;
    res.drive_level  = running_nxt ? DRIVE_W'(cur_set_r * DRIVE_STEP) : '0;
    res.cutoff_hit   = hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r   <= 1'b0;
      rem_r       <= '0;
      mah_r       <= '0;
      last_cur_r  <= '0;
      last_vol_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      running_r  <= running_nxt;
      rem_r      <= rem_nxt;
      mah_r      <= mah_nxt;
      last_cur_r <= last_cur_nxt;
      last_vol_r <= last_vol_nxt;
      if (adv_out) out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire4) out_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-$bits(result_t)){1'b0}}, out_r};

  // ---------------- assertions ----------------
  `DCM_ASSERT_NOW(a_rem_bounded, 1'b1, rem_r <= MAS_PER_MAH)
  `DCM_ASSERT_NOW(a_tick_in_window, 1'b1, tick_r < WINDOW)
  `DCM_ASSERT_NOW(a_hit_stops, out_valid_r && out_r.cutoff_hit, !out_r.discharging)
  `DCM_ASSERT_NOW(a_idle_no_drive, out_valid_r && !out_r.discharging, out_r.drive_level == '0)
  `DCM_ASSERT_NEXT(a_mah_step, mah_nxt != mah_r, mah_r == $past(mah_r) + 1'b1)

endmodule
